@@ design/gated_phase_difference_tracker_core_defines.svh @@
// ----------------------------------------------------------------------------
// Gated phase difference tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GATED_PHASE_DIFFERENCE_TRACKER_CORE_DEFINES_SVH
`define GATED_PHASE_DIFFERENCE_TRACKER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GPDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gpdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Gated phase difference tracker package
// Command and status types, datapath operation codes and fixed constants.
// ----------------------------------------------------------------------------
package gpdt_pkg;

  localparam int COEFF_W = 24;
  localparam int RATIO_W = 15;
  localparam int BAND_W  = 16;
  localparam int CORR_W  = 18;
  localparam int PHASE_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 3'd4;

  localparam logic [23:0] ENV_MAX   = 24'hFFFFFF;
  localparam int          ABS_FLOOR = 17;
  localparam int          MAG2_MIN  = 115;
  localparam int          UNIT      = 65536;
  localparam int          PI_Q20    = 3294199;
  localparam int          PI_Q13    = 25736;
  localparam int          CORDIC_STEPS = 20;
  localparam int          SQRT_STEPS   = 32;
  localparam int          DIV_STEPS    = 18;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE   = 5'd0;
  localparam op_t OP_LOAD   = 5'd1;
  localparam op_t OP_ENV_F  = 5'd2;
  localparam op_t OP_ENV_S  = 5'd3;
  localparam op_t OP_THR    = 5'd4;
  localparam op_t OP_ZR     = 5'd5;
  localparam op_t OP_ZI     = 5'd6;
  localparam op_t OP_M2A    = 5'd7;
  localparam op_t OP_M2B    = 5'd8;
  localparam op_t OP_SQ_INIT = 5'd9;
  localparam op_t OP_SQ_STEP = 5'd10;
  localparam op_t OP_DV_INIT = 5'd11;
  localparam op_t OP_DV_STEP = 5'd12;
  localparam op_t OP_DV_END  = 5'd13;
  localparam op_t OP_BLEND   = 5'd14;
  localparam op_t OP_N2A     = 5'd15;
  localparam op_t OP_N2B     = 5'd16;
  localparam op_t OP_COMMIT  = 5'd17;
  localparam op_t OP_CR_INIT = 5'd18;
  localparam op_t OP_CR_STEP = 5'd19;
  localparam op_t OP_OUT     = 5'd20;

  typedef struct packed {
    op_t        op;
    logic [4:0] step;
    logic       sel;   // 0: cosine or real part, 1: sine or imaginary part
    logic       pass;  // 0: band product normalization, 1: phasor renormalization
  } cmd_t;

  typedef struct packed {
    logic mag_big;
    logic nonzero;
    logic eob;
    logic out_free;
  } sts_t;

  function automatic logic [19:0] atan_entry(input logic [4:0] i);
    logic [19:0] v;
    unique case (i)
      5'd0:  v = 20'd823550;
      5'd1:  v = 20'd486170;
      5'd2:  v = 20'd256879;
      5'd3:  v = 20'd130396;
      5'd4:  v = 20'd65451;
      5'd5:  v = 20'd32757;
      5'd6:  v = 20'd16383;
      5'd7:  v = 20'd8192;
      5'd8:  v = 20'd4096;
      5'd9:  v = 20'd2048;
      5'd10: v = 20'd1024;
      5'd11: v = 20'd512;
      5'd12: v = 20'd256;
      5'd13: v = 20'd128;
      5'd14: v = 20'd64;
      5'd15: v = 20'd32;
      5'd16: v = 20'd16;
      5'd17: v = 20'd8;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/gated_phase_difference_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Gated phase difference tracker core
// Tracks the smoothed phase difference between two band signals, gated by a
// broadband transient detector, and reports it at the end of each block.
// ----------------------------------------------------------------------------
// The input channel carries one sample time per transfer: the broadband
// sidechain sample, the complex band values of sidechain and main, and an
// end-of-block mark. The output channel carries one result transfer for each
// sample that ends a block: the smoothed phasor cosine, its angle and the
// sticky transient flag. Samples without the mark produce no result.
// One sample is processed at a time: the core takes no new sample before it
// is through with the last. A sample whose band product is too small to use
// leaves the phasor alone. A sample that updates the phasor runs the
// bit-serial square root, with its setup step, and the restoring divider,
// once per component, each of them twice. An end-of-block sample then runs
// the CORDIC angle; its result is written once the output register is free.
// Reset is synchronous: registers go to their default coefficients, the
// envelopes clear and the phasor returns to angle zero.
// The result sits in an output register. If the receiver stalls, the next
// sample is still taken and processed; only a second result waits for the
// register to empty. Configuration writes land at once and belong in idle time.
// ----------------------------------------------------------------------------
`include "gated_phase_difference_tracker_core_defines.svh"

module gated_phase_difference_tracker_core #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEFF_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gpdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpdt_pkg::COEFF_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_raw_sample,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_side_real,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_side_imag,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_main_real,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_main_imag,
  input  logic                                in_end_of_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gpdt_pkg::CORR_W-1:0]  out_correlation,
  output logic signed [gpdt_pkg::PHASE_W-1:0] out_phase_delta,
  output logic                                out_valid_res
);
  import gpdt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns sequencing; all arithmetic lives in the datapath.
  gpdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpdt_dp #(
    .SW  (SAMPLE_WIDTH),
    .CFB (COEFF_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_raw_sample   (in_raw_sample),
    .in_side_real    (in_side_real),
    .in_side_imag    (in_side_imag),
    .in_main_real    (in_main_real),
    .in_main_imag    (in_main_imag),
    .in_end_of_block (in_end_of_block),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_correlation (out_correlation),
    .out_phase_delta (out_phase_delta),
    .out_valid_res   (out_valid_res)
  );

  // Only one sample is in flight, so ready drops right after a transfer.
  `GPDT_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "ready after transfer")
  // Input registers are loaded only on a real input transfer.
  `GPDT_ASSERT_IMP(a_load_on_xfer, cmd.op == OP_LOAD, in_valid && in_ready, "load without transfer")
  // A new result never overwrites one the receiver has not taken.
  `GPDT_ASSERT_IMP(a_no_overwrite, cmd.op == OP_OUT, !out_valid || out_ready, "result overwritten")

endmodule

@@ design/gpdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// Gated phase difference tracker controller
// Sequences the datapath operations for one sample and the result hand-off.
// ----------------------------------------------------------------------------
module gpdt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gpdt_pkg::sts_t sts,
  output gpdt_pkg::cmd_t cmd
);
  import gpdt_pkg::*;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_ENVF   = 5'd1;
  localparam logic [4:0] ST_ENVS   = 5'd2;
  localparam logic [4:0] ST_THR    = 5'd3;
  localparam logic [4:0] ST_ZR     = 5'd4;
  localparam logic [4:0] ST_ZI     = 5'd5;
  localparam logic [4:0] ST_M2A    = 5'd6;
  localparam logic [4:0] ST_M2B    = 5'd7;
  localparam logic [4:0] ST_GATE   = 5'd8;
  localparam logic [4:0] ST_SQI    = 5'd9;
  localparam logic [4:0] ST_SQS    = 5'd10;
  localparam logic [4:0] ST_DVI    = 5'd11;
  localparam logic [4:0] ST_DVS    = 5'd12;
  localparam logic [4:0] ST_DVE    = 5'd13;
  localparam logic [4:0] ST_BLC    = 5'd14;
  localparam logic [4:0] ST_BLS    = 5'd15;
  localparam logic [4:0] ST_N2A    = 5'd16;
  localparam logic [4:0] ST_N2B    = 5'd17;
  localparam logic [4:0] ST_NZ     = 5'd18;
  localparam logic [4:0] ST_COMMIT = 5'd19;
  localparam logic [4:0] ST_EOB    = 5'd20;
  localparam logic [4:0] ST_CRI    = 5'd21;
  localparam logic [4:0] ST_CRS    = 5'd22;
  localparam logic [4:0] ST_OUT    = 5'd23;

  logic [4:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;
  logic       pass_r, pass_nxt;
  op_t        op;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    pass_nxt  = pass_r;
    op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_ENVF;
        end
      end
      ST_ENVF: begin op = OP_ENV_F; state_nxt = ST_ENVS; end
      ST_ENVS: begin op = OP_ENV_S; state_nxt = ST_THR; end
      ST_THR:  begin op = OP_THR;   state_nxt = ST_ZR; end
      ST_ZR:   begin op = OP_ZR;    state_nxt = ST_ZI; end
      ST_ZI:   begin op = OP_ZI;    state_nxt = ST_M2A; end
      ST_M2A:  begin op = OP_M2A;   state_nxt = ST_M2B; end
      ST_M2B:  begin op = OP_M2B;   state_nxt = ST_GATE; end
      ST_GATE: begin
        pass_nxt  = 1'b0;
        state_nxt = sts.mag_big ? ST_SQI : ST_EOB;
      end
      ST_SQI: begin
        op        = OP_SQ_INIT;
        cnt_nxt   = 5'(SQRT_STEPS - 1);
        state_nxt = ST_SQS;
      end
      ST_SQS: begin
        op = OP_SQ_STEP;
        if (cnt_r == 5'd0) begin
          sel_nxt   = 1'b0;
          state_nxt = ST_DVI;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_DVI: begin
        op        = OP_DV_INIT;
        cnt_nxt   = 5'(DIV_STEPS - 1);
        state_nxt = ST_DVS;
      end
      ST_DVS: begin
        op = OP_DV_STEP;
        if (cnt_r == 5'd0) begin
          state_nxt = ST_DVE;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      ST_DVE: begin
        op = OP_DV_END;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = ST_DVI;
        end else if (!pass_r) begin
          state_nxt = ST_BLC;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_BLC: begin op = OP_BLEND; sel_nxt = 1'b1; state_nxt = ST_BLS; end
      ST_BLS: begin op = OP_BLEND; state_nxt = ST_N2A; end
      ST_N2A: begin op = OP_N2A; state_nxt = ST_N2B; end
      ST_N2B: begin op = OP_N2B; state_nxt = ST_NZ; end
      ST_NZ: begin
        pass_nxt  = 1'b1;
        state_nxt = sts.nonzero ? ST_SQI : ST_COMMIT;
      end
      ST_COMMIT: begin op = OP_COMMIT; state_nxt = ST_EOB; end
      ST_EOB: begin
        state_nxt = sts.eob ? ST_CRI : ST_IDLE;
      end
      ST_CRI: begin
        op        = OP_CR_INIT;
        cnt_nxt   = 5'd0;
        state_nxt = ST_CRS;
      end
      ST_CRS: begin
        op = OP_CR_STEP;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          op        = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 5'd0;
      sel_r   <= 1'b0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // In the cosine blend state the select follows the state rather than the register.
  assign cmd.op   = op;
  assign cmd.step = cnt_r;
  assign cmd.sel  = (state_r == ST_BLC) ? 1'b0 : sel_r;
  assign cmd.pass = pass_r;
  assign in_ready = (state_r == ST_IDLE);

endmodule

@@ design/gpdt_dp.sv @@
// ----------------------------------------------------------------------------
// Gated phase difference tracker datapath
// Envelopes, band product, bit-serial root and divider, blend, CORDIC, output.
// ----------------------------------------------------------------------------
module gpdt_dp #(
  parameter int SW  = 16,
  parameter int CFB = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gpdt_pkg::cmd_t                      cmd,
  output gpdt_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [gpdt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpdt_pkg::COEFF_W-1:0]        cfg_wdata,
  input  logic signed [SW-1:0]                in_raw_sample,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_side_real,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_side_imag,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_main_real,
  input  logic signed [gpdt_pkg::BAND_W-1:0]  in_main_imag,
  input  logic                                in_end_of_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gpdt_pkg::CORR_W-1:0]  out_correlation,
  output logic signed [gpdt_pkg::PHASE_W-1:0] out_phase_delta,
  output logic                                out_valid_res
);
  import gpdt_pkg::*;

  localparam int KW = CFB + 1;
  localparam int SH = 24 - (SW - 1);

  // Coefficients above one are used as exactly one.
  function automatic logic [KW-1:0] coeff_val(input logic [COEFF_W-1:0] c);
    logic [31:0] one;
    one = 32'd1 << CFB;
    if ({8'd0, c} > one) return one[KW-1:0];
    return KW'(c);
  endfunction

  // Configuration
  logic [COEFF_W-1:0] fast_r, slow_r, attack_r, release_r;
  logic [RATIO_W-1:0] ratio_r;

  // Captured item
  logic signed [SW-1:0]     raw_r;
  logic signed [BAND_W-1:0] sr_r, si_r, mr_r, mi_r;
  logic                     eob_r;

  // Tracker state
  logic [23:0]        fenv_r, sfloor_r;
  logic signed [17:0] pc_r, ps_r;
  logic               ever_r, active_r;

  // Working registers
  logic signed [32:0] zr_r, zi_r;
  logic [63:0]        mag2_r;
  logic [63:0]        rt_v_r, rt_q_r;
  logic [63:0]        dv_num_r;
  logic [17:0]        dv_q_r;
  logic               dv_neg_r;
  logic signed [17:0] ic_r, is_r, c_r, s_r;
  logic signed [35:0] cx_r, cy_r;
  logic signed [24:0] cz_r;
  logic               zero_r;

  // Output register
  logic                       ovalid_r;
  logic signed [CORR_W-1:0]   ocorr_r;
  logic signed [PHASE_W-1:0]  ophase_r;
  logic                       oact_r;

  // Combinational helpers
  logic [SW-1:0]      rmag;
  logic [24:0]        rsh;
  logic [23:0]        xabs;
  logic [23:0]        eb_a, eb_c, eb_res;
  logic [KW-1:0]      eb_k;
  logic signed [24:0] eb_d;
  logic signed [63:0] eb_p;
  logic [63:0]        eb_s;
  logic [39:0]        thr_s;
  logic [27:0]        thr_q, thr_f;
  logic               act;
  logic signed [31:0] m_a, m_b;
  logic signed [32:0] zsum;
  logic signed [32:0] sq_sel;
  logic [31:0]        sq_in;
  logic [63:0]        sq_prod;
  logic [63:0]        rt_bit, rt_t;
  logic [31:0]        den;
  logic signed [32:0] dv_x;
  logic [31:0]        dv_mag;
  logic [63:0]        dv_t;
  logic [17:0]        dv_qc;
  logic signed [17:0] dv_res;
  logic [KW-1:0]      bl_b;
  logic signed [17:0] bl_pv, bl_iv, bl_res;
  logic signed [18:0] bl_d;
  logic signed [63:0] bl_p, bl_s;
  logic [63:0]        bl_m, bl_r;
  logic signed [35:0] cx_xs, cy_ys;
  logic signed [24:0] cz_t;
  logic [24:0]        ph_m, ph_r;
  logic [15:0]        ph_c;
  logic signed [15:0] ph_res;

  always_comb begin
    rmag = raw_r[SW-1] ? SW'(-raw_r) : SW'(raw_r);
    rsh  = 25'(rmag) << SH;
    xabs = rsh[24] ? ENV_MAX : rsh[23:0];

    eb_a = (cmd.op == OP_ENV_F) ? fenv_r : sfloor_r;
    eb_c = ((cmd.op == OP_ENV_F) && (xabs > fenv_r)) ? fast_r : slow_r;
    eb_k = coeff_val(eb_c);
    eb_d = $signed({1'b0, eb_a}) - $signed({1'b0, xabs});
    eb_p = $signed({1'b0, eb_k}) * eb_d;
    eb_s = (64'(xabs) << CFB) + $unsigned(eb_p) + (64'd1 << (CFB - 1));
    eb_res = eb_s[CFB +: 24];

    thr_s = 40'(sfloor_r) * 40'(ratio_r) + 40'd2048;
    thr_q = thr_s[39:12];
    thr_f = (thr_q < 28'(ABS_FLOOR)) ? 28'(ABS_FLOOR) : thr_q;
    act   = 28'(fenv_r) > thr_f;

    m_a  = (cmd.op == OP_ZR) ? sr_r * mr_r : si_r * mr_r;
    m_b  = (cmd.op == OP_ZR) ? si_r * mi_r : sr_r * mi_r;
    zsum = (cmd.op == OP_ZR) ? m_a + m_b : m_a - m_b;

    unique case (cmd.op)
      OP_M2B:  sq_sel = zi_r;
      OP_N2A:  sq_sel = 33'(c_r);
      OP_N2B:  sq_sel = 33'(s_r);
      default: sq_sel = zr_r;
    endcase
    sq_in   = sq_sel[32] ? 32'(-sq_sel) : 32'(sq_sel);
    sq_prod = 64'(sq_in) * 64'(sq_in);

    rt_bit = 64'd1 << {cmd.step, 1'b0};
    rt_t   = rt_q_r + rt_bit;
    den    = rt_q_r[31:0];

    if (cmd.pass) dv_x = cmd.sel ? 33'(s_r) : 33'(c_r);
    else          dv_x = cmd.sel ? zi_r : zr_r;
    dv_mag = dv_x[32] ? 32'(-dv_x) : 32'(dv_x);
    dv_t   = 64'(den) << cmd.step;
    dv_qc  = (dv_q_r > 18'(UNIT)) ? 18'(UNIT) : dv_q_r;
    dv_res = dv_neg_r ? -$signed(dv_qc) : $signed(dv_qc);

    bl_b   = coeff_val(active_r ? attack_r : release_r);
    bl_pv  = cmd.sel ? ps_r : pc_r;
    bl_iv  = cmd.sel ? is_r : ic_r;
    bl_d   = bl_pv - bl_iv;
    bl_p   = $signed({1'b0, bl_b}) * bl_d;
    bl_s   = (64'(bl_iv) <<< CFB) + bl_p;
    bl_m   = bl_s[63] ? $unsigned(-bl_s) : $unsigned(bl_s);
    bl_r   = (bl_m + (64'd1 << (CFB - 1))) >> CFB;
    bl_res = bl_s[63] ? -$signed(bl_r[17:0]) : $signed(bl_r[17:0]);

    cx_xs = cx_r >>> cmd.step;
    cy_ys = cy_r >>> cmd.step;
    cz_t  = $signed({5'd0, atan_entry(cmd.step)});

    ph_m   = cz_r[24] ? 25'(-cz_r) : 25'(cz_r);
    ph_r   = (ph_m + 25'd64) >> 7;
    ph_c   = (ph_r > 25'(PI_Q13)) ? 16'(PI_Q13) : ph_r[15:0];
    if (zero_r)        ph_res = '0;
    else if (cz_r[24]) ph_res = -$signed(ph_c);
    else               ph_res = $signed(ph_c);
  end

  // Configuration and state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r    <= 24'd16603323;
      slow_r    <= 24'd16774886;
      attack_r  <= 24'd16707456;
      release_r <= 24'd16776051;
      ratio_r   <= 15'd10445;
      fenv_r    <= '0;
      sfloor_r  <= '0;
      pc_r      <= 18'(UNIT);
      ps_r      <= '0;
      ever_r    <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FAST:    fast_r    <= cfg_wdata;
          CFG_SLOW:    slow_r    <= cfg_wdata;
          CFG_ATTACK:  attack_r  <= cfg_wdata;
          CFG_RELEASE: release_r <= cfg_wdata;
          CFG_RATIO:   ratio_r   <= cfg_wdata[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_ENV_F) fenv_r   <= eb_res;
      if (cmd.op == OP_ENV_S) sfloor_r <= eb_res;
      if (cmd.op == OP_THR)   ever_r   <= ever_r | act;
      if (cmd.op == OP_COMMIT) begin
        pc_r <= c_r;
        ps_r <= s_r;
      end
      if (cmd.op == OP_OUT)   ovalid_r <= 1'b1;
      else if (out_ready)     ovalid_r <= 1'b0;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        raw_r <= in_raw_sample;
        sr_r  <= in_side_real;
        si_r  <= in_side_imag;
        mr_r  <= in_main_real;
        mi_r  <= in_main_imag;
        eob_r <= in_end_of_block;
      end
      OP_THR:  active_r <= act;
      OP_ZR:   zr_r <= zsum;
      OP_ZI:   zi_r <= zsum;
      OP_M2A, OP_N2A: mag2_r <= sq_prod;
      OP_M2B, OP_N2B: mag2_r <= mag2_r + sq_prod;
      OP_SQ_INIT: begin
        rt_v_r <= cmd.pass ? (mag2_r << 28) : mag2_r;
        rt_q_r <= '0;
      end
      OP_SQ_STEP: begin
        if (rt_v_r >= rt_t) begin
          rt_v_r <= rt_v_r - rt_t;
          rt_q_r <= (rt_q_r >> 1) + rt_bit;
        end else begin
          rt_q_r <= rt_q_r >> 1;
        end
      end
      OP_DV_INIT: begin
        dv_num_r <= (64'(dv_mag) << (cmd.pass ? 30 : 16)) + 64'(den >> 1);
        dv_q_r   <= '0;
        dv_neg_r <= dv_x[32];
      end
      OP_DV_STEP: begin
        if (dv_num_r >= dv_t) begin
          dv_num_r <= dv_num_r - dv_t;
          dv_q_r   <= dv_q_r | (18'd1 << cmd.step);
        end
      end
      OP_DV_END: begin
        if (cmd.pass) begin
          if (cmd.sel) s_r <= dv_res;
          else         c_r <= dv_res;
        end else begin
          if (cmd.sel) is_r <= dv_res;
          else         ic_r <= dv_res;
        end
      end
      OP_BLEND: begin
        if (cmd.sel) s_r <= bl_res;
        else         c_r <= bl_res;
      end
      OP_CR_INIT: begin
        zero_r <= (pc_r == 18'sd0) && (ps_r == 18'sd0);
        if (pc_r[17]) begin
          cz_r <= ps_r[17] ? -25'(PI_Q20) : 25'(PI_Q20);
          cx_r <= (-36'(pc_r)) <<< 12;
          cy_r <= (-36'(ps_r)) <<< 12;
        end else begin
          cz_r <= '0;
          cx_r <= 36'(pc_r) <<< 12;
          cy_r <= 36'(ps_r) <<< 12;
        end
      end
      OP_CR_STEP: begin
        if (cy_r > 36'sd0) begin
          cx_r <= cx_r + cy_ys;
          cy_r <= cy_r - cx_xs;
          cz_r <= cz_r + cz_t;
        end else begin
          cx_r <= cx_r - cy_ys;
          cy_r <= cy_r + cx_xs;
          cz_r <= cz_r - cz_t;
        end
      end
      OP_OUT: begin
        ocorr_r  <= pc_r;
        ophase_r <= ph_res;
        oact_r   <= ever_r;
      end
      default: ;
    endcase
  end

  assign sts.mag_big  = mag2_r > 64'(MAG2_MIN);
  assign sts.nonzero  = mag2_r != 64'd0;
  assign sts.eob      = eob_r;
  assign sts.out_free = !ovalid_r || out_ready;

  assign out_valid       = ovalid_r;
  assign out_correlation = ocorr_r;
  assign out_phase_delta = ophase_r;
  assign out_valid_res   = oact_r;

endmodule

@@ bench/tb_gated_phase_difference_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gated phase difference tracker core testbench
// Streams sample times into the core with random gaps and result stalls. It
// mirrors the envelope gate, phasor blend and angle arithmetic bit for bit,
// and checks every end-of-block result against that prediction.
// ----------------------------------------------------------------------------
module tb_gated_phase_difference_tracker_core;
  import gpdt_pkg::*;

  localparam int IDLE_LIMIT   = 20000;  // cycles without any transfer
  localparam int SETTLE_WAIT  = 250;    // longer than one phasor update
  localparam int STALL_CYCLES = 3000;   // long receiver hold-off

  typedef struct {
    logic signed [15:0] raw;
    logic signed [15:0] sr, si, mr, mi;
    logic               eob;
  } sample_t;

  typedef struct {
    logic signed [CORR_W-1:0]  corr;
    logic signed [PHASE_W-1:0] phase;
    logic                      vres;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_raw_sample = '0;
  logic signed [BAND_W-1:0] in_side_real = '0, in_side_imag = '0;
  logic signed [BAND_W-1:0] in_main_real = '0, in_main_imag = '0;
  logic in_end_of_block = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CORR_W-1:0] out_correlation;
  logic signed [PHASE_W-1:0] out_phase_delta;
  logic out_valid_res;

  always #4 clk = ~clk;

  gated_phase_difference_tracker_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_raw_sample(in_raw_sample),
    .in_side_real(in_side_real), .in_side_imag(in_side_imag),
    .in_main_real(in_main_real), .in_main_imag(in_main_imag),
    .in_end_of_block(in_end_of_block),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_correlation(out_correlation), .out_phase_delta(out_phase_delta),
    .out_valid_res(out_valid_res)
  );

  // Samples waiting to be offered, and block results still owed by the core.
  sample_t pending_samples[$];
  result_t owed_results[$];
  sample_t cur_sample;
  bit      cur_taken = 1'b0;
  int      fail_count = 0;

  // Idling controls set per phase by the stimulus process.
  bit steady_tx = 1'b0;
  bit steady_rx = 1'b0;
  int stall_requests = 0;

  // Mirror of the core's registers and state.
  logic [23:0] m_fast, m_slow, m_attack, m_release;
  logic [14:0] m_ratio;
  longint unsigned env_fast, env_floor;
  longint ph_cos, ph_sin;
  bit seen_active;

  longint atan_steps[CORDIC_STEPS] = '{823550, 486170, 256879, 130396, 65451, 32757,
    16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic longint shift_round(input longint v, input int sh);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(-v) : v;
    r = (mag + ((64'd1 << sh) >> 1)) >> sh;
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  // round(v * 2^sh / den), clamped to one in Q1.16.
  function automatic longint unit_quot(input longint v, input int sh,
                                       input longint unsigned den);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : v;
    q = ((mag << sh) + (den >> 1)) / den;
    if (q > UNIT) q = UNIT;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned smooth(input logic [23:0] c,
                                             input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned k;
    k = c;
    return (k * a + ((64'd1 << 24) - k) * b + (64'd1 << 23)) >> 24;
  endfunction

  function automatic longint phase_of(input longint y, input longint x);
    longint z, xs, ys, a;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q20 : -PI_Q20;
      x = -x;
      y = -y;
    end
    x = x * 4096;
    y = y * 4096;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_steps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_steps[i];
      end
    end
    a = shift_round(z, 7);
    if (a > PI_Q13) a = PI_Q13;
    if (a < -PI_Q13) a = -PI_Q13;
    return a;
  endfunction

  // Advances the mirror by one sample time and queues the block result if
  // the sample closes a block.
  function automatic void track_sample(input sample_t s);
    longint raw, zr, zi, ic, is, b, c, sn;
    longint unsigned xabs, thr, mag2, mag, n2, n;
    bit active;
    result_t r;
    raw = s.raw;
    xabs = ((raw < 0) ? -raw : raw) << 9;
    if (xabs > ENV_MAX) xabs = ENV_MAX;
    env_fast = (xabs > env_fast) ? smooth(m_fast, env_fast, xabs)
                                 : smooth(m_slow, env_fast, xabs);
    env_floor = smooth(m_slow, env_floor, xabs);
    thr = (env_floor * m_ratio + 2048) >> 12;
    if (thr < ABS_FLOOR) thr = ABS_FLOOR;
    active = env_fast > thr;
    seen_active = seen_active | active;

    zr = longint'(s.sr) * s.mr + longint'(s.si) * s.mi;
    zi = longint'(s.si) * s.mr - longint'(s.sr) * s.mi;
    mag2 = longint'(zr * zr) + longint'(zi * zi);
    // Products too small to carry a direction leave the phasor alone.
    if (mag2 > MAG2_MIN) begin
      mag = int_sqrt(mag2);
      ic = unit_quot(zr, 16, mag);
      is = unit_quot(zi, 16, mag);
      b = active ? m_attack : m_release;
      c = shift_round(b * ph_cos + ((64'sd1 << 24) - b) * ic, 24);
      sn = shift_round(b * ph_sin + ((64'sd1 << 24) - b) * is, 24);
      n2 = longint'(c * c) + longint'(sn * sn);
      // A blend that cancels to the origin is kept as it is.
      if (n2 > 0) begin
        n = int_sqrt(n2 << 28);
        c = unit_quot(c, 30, n);
        sn = unit_quot(sn, 30, n);
      end
      ph_cos = c;
      ph_sin = sn;
    end
    if (s.eob) begin
      r.corr = ph_cos[CORR_W-1:0];
      r.phase = PHASE_W'(phase_of(ph_sin, ph_cos));
      r.vres = seen_active;
      owed_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s is %0d, predicted %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Sender: a new sample is put up only once the previous one was taken,
  // so valid and payload hold steady while the core is busy.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || cur_taken)) begin
      cur_taken = 1'b0;
      if (pending_samples.size() > 0 && (steady_tx || $urandom_range(99) >= 30)) begin
        cur_sample = pending_samples.pop_front();
        in_raw_sample <= cur_sample.raw;
        in_side_real <= cur_sample.sr;
        in_side_imag <= cur_sample.si;
        in_main_real <= cur_sample.mr;
        in_main_imag <= cur_sample.mi;
        in_end_of_block <= cur_sample.eob;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested so
  // that the output register fills and the core stops taking samples.
  int stalls_served = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (stall_requests != stalls_served) begin
      stalls_served = stall_requests;
      hold_left = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_rx || ($urandom_range(99) >= 30);
    end
  end

  // Both channels are observed on the rising edge.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      track_sample(cur_sample);
      cur_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("ERROR at %0t: result transfer with none outstanding", $time);
        fail_count++;
      end else begin
        result_t w;
        w = owed_results.pop_front();
        if (out_correlation !== w.corr)
          report_mismatch("correlation", out_correlation, w.corr);
        if (out_phase_delta !== w.phase)
          report_mismatch("phase_delta", out_phase_delta, w.phase);
        if (out_valid_res !== w.vres)
          report_mismatch("valid_res", out_valid_res, w.vres);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic sample_t make_sample(input int raw, input int sr, input int si,
                                          input int mr, input int mi, input bit eob);
    sample_t s;
    s.raw = 16'(raw);
    s.sr = 16'(sr);
    s.si = 16'(si);
    s.mr = 16'(mr);
    s.mi = 16'(mi);
    s.eob = eob;
    return s;
  endfunction

  function automatic logic signed [15:0] band_value(input int mode);
    int pick;
    pick = $urandom_range(2);
    if (mode == 0) return 16'($urandom_range(8) - 4);
    if (mode == 1) return (pick == 0) ? 16'sh8000 : ((pick == 1) ? 16'sh7FFF : 16'sh0000);
    return 16'($urandom);
  endfunction

  // Bursts of loud samples over a quiet background drive the transient gate
  // on and off; the band values are mostly full range.
  task automatic queue_random(input int count);
    bit loud;
    int run;
    int mode;
    sample_t s;
    loud = 1'b0;
    run = 0;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        loud = ~loud;
        run = $urandom_range(40, 5);
      end
      run--;
      s.raw = loud ? 16'($urandom) : 16'($urandom_range(64) - 32);
      mode = $urandom_range(9);
      s.sr = band_value(mode);
      s.si = band_value(mode);
      s.mr = band_value(mode);
      s.mi = band_value(mode);
      s.eob = ($urandom_range(3) == 0);
      pending_samples.push_back(s);
    end
  endtask

  // Waits until every sample was taken and every result arrived, then lets
  // a sample that produces no result finish inside the core.
  task automatic drain;
    while (pending_samples.size() > 0 || in_valid || owed_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FAST:    m_fast = val;
      CFG_SLOW:    m_slow = val;
      CFG_ATTACK:  m_attack = val;
      CFG_RELEASE: m_release = val;
      CFG_RATIO:   m_ratio = val[14:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [23:0] f, input logic [23:0] s, input logic [23:0] a,
                           input logic [23:0] r, input logic [14:0] q);
    write_reg(CFG_FAST, f);
    write_reg(CFG_SLOW, s);
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_RATIO, 24'(q));
  endtask

  initial begin
    m_fast = 24'd16603323;
    m_slow = 24'd16774886;
    m_attack = 24'd16707456;
    m_release = 24'd16776051;
    m_ratio = 15'd10445;
    env_fast = 0;
    env_floor = 0;
    ph_cos = UNIT;
    ph_sin = 0;
    seen_active = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default coefficients: silent start, full-scale and saturating samples,
    // band products just below and just above the usable minimum.
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 1));
    pending_samples.push_back(make_sample(32767, 32767, 0, 32767, 0, 0));
    pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, 1));
    pending_samples.push_back(make_sample(-32768, -32768, 32767, 32767, -32768, 0));
    pending_samples.push_back(make_sample(5, 3, 0, 3, 0, 1));
    pending_samples.push_back(make_sample(-5, 11, 0, 1, 0, 1));
    pending_samples.push_back(make_sample(0, 0, 20000, 20000, 0, 0));
    pending_samples.push_back(make_sample(1, 0, 0, -32768, 32767, 1));
    drain();

    // Zero blend coefficients make the phasor follow each product exactly:
    // a negative real product has zero sine and must read as plus pi.
    write_all(24'd0, 24'd0, 24'd0, 24'd0, 15'd4506);
    pending_samples.push_back(make_sample(100, 1000, 0, 1000, 0, 1));
    pending_samples.push_back(make_sample(-100, -1000, 0, 1000, 0, 1));
    pending_samples.push_back(make_sample(200, 0, -30000, 30000, 0, 1));
    pending_samples.push_back(make_sample(300, 30000, 30000, 30000, 0, 1));
    pending_samples.push_back(make_sample(0, 16384, 0, 16384, 0, 0));
    drain();

    // A half blend of opposite phasors cancels to the origin, which gives a
    // zero cosine and a zero angle.
    write_all(24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h800000, 15'd16384);
    pending_samples.push_back(make_sample(32767, -16384, 0, 16384, 0, 1));
    pending_samples.push_back(make_sample(-32768, 1234, -4321, 777, 999, 1));
    drain();

    steady_tx = 1'b1;
    steady_rx = 1'b1;
    write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
              15'($urandom_range(16384, 4506)));
    queue_random(135);
    drain();
    steady_tx = 1'b0;
    steady_rx = 1'b0;

    // Opposite extremes, with a ratio of zero outside the intended range.
    write_all(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0, 15'd0);
    queue_random(135);
    drain();

    // The receiver holds off while samples keep coming.
    write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 15'h7FFF);
    stall_requests++;
    queue_random(135);
    drain();

    write_all(24'($urandom_range(24'hFFFFFF, 24'hF00000)),
              24'($urandom_range(24'hFFFFFF, 24'hFF0000)),
              24'($urandom_range(24'hFFFFFF, 24'hF00000)),
              24'($urandom_range(24'hFFFFFF, 24'hFF0000)),
              15'($urandom_range(16384, 4506)));
    queue_random(135);
    drain();

    write_all(24'd16603323, 24'd16774886, 24'd16707456, 24'd16776051, 15'd10445);
    queue_random(135);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
